// ===== src/tapb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tapb_pkg;

   // Fixed field widths
   localparam int BLK_W  = 6;
   localparam int CNT_W  = 7;
   localparam int CO_W   = 2;
   localparam int DIM_W  = 3;
   localparam int PERM_W = 8;
   localparam int DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Address arithmetic widths, sized for dims up to 7 and coordinates up to 3
   localparam int T1_W   = 5;   // 7*3+3
   localparam int T2_W   = 8;   // 7*24+3
   localparam int T3_W   = 11;  // 7*171+3
   localparam int VAB_W  = 6;   // 7*7
   localparam int VOL_W  = 12;  // 49*49
   localparam int BOFF_W = 18;  // 63*2401
   localparam int SUM_W  = 19;

   localparam logic ACT_STORE = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   localparam logic [PERM_W-1:0] PERM_RESET  = 8'd228;
   localparam logic [CNT_W-1:0]  COUNT_RESET = 7'd1;
   localparam logic [DIM_W-1:0]  DIM_A_RESET = 3'd4;
   localparam logic [DIM_W-1:0]  DIM_B_RESET = 3'd4;
   localparam logic [DIM_W-1:0]  DIM_C_RESET = 3'd4;
   localparam logic [DIM_W-1:0]  DIM_D_RESET = 3'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERM_CODE   = 3'd0,
      CSR_BLOCK_COUNT = 3'd1,
      CSR_DIM_A       = 3'd2,
      CSR_DIM_B       = 3'd3,
      CSR_DIM_C       = 3'd4,
      CSR_DIM_D       = 3'd5
   } csr_index_type;

   // Effective (saturated) configuration seen by the address pipeline
   typedef struct packed {
      logic [PERM_W-1:0]            perm;
      logic [CNT_W-1:0]             blocks;
      logic [3:0][DIM_W-1:0]        dim;
   } cfg_type;

   typedef struct packed {
      logic                         action;
      logic [BLK_W-1:0]             blk;
      logic [3:0][CO_W-1:0]         co;
      logic [DATA_W-1:0]            real_bits;
      logic [DATA_W-1:0]            imag_bits;
   } item_type;

   // Per-stage control that travels with each item
   typedef struct packed {
      logic valid;
      logic is_read;
      logic bad;
   } ctl_type;

endpackage

`default_nettype wire

// ===== src/tapb_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tapb_mem #(
   parameter int DEPTH  = 16384,
   parameter int ADDR_W = 14,
   parameter int DATA_W = 128
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wdata,
   output logic      [DATA_W-1:0] rdata_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/tapb_addr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tapb_addr #(
   parameter int ADDR_W = 14
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire tapb_pkg::item_type     item,
   input  wire tapb_pkg::cfg_type      cfg,
   output tapb_pkg::ctl_type           cmd,
   output logic [ADDR_W-1:0]           addr,
   output logic [2*tapb_pkg::DATA_W-1:0] data
);

   localparam int DW = 2*tapb_pkg::DATA_W;

   // Stage 1 inputs
   tapb_pkg::ctl_type                                ctl_in;
   logic [3:0][tapb_pkg::CO_W-1:0]                   x_in;
   logic [3:1][tapb_pkg::DIM_W-1:0]                  st_in;

   // Stage 1
   tapb_pkg::ctl_type                                ctl1_ff;
   logic [3:0][tapb_pkg::CO_W-1:0]                   x1_ff;
   logic [3:1][tapb_pkg::DIM_W-1:0]                  st1_ff;
   logic [tapb_pkg::VAB_W-1:0]                       vab1_ff, vcd1_ff;
   logic [tapb_pkg::BLK_W-1:0]                       blk1_ff;
   logic [DW-1:0]                                    data1_ff;

   // Stage 2
   tapb_pkg::ctl_type                                ctl2_ff;
   logic [tapb_pkg::T1_W-1:0]                        t1_ff;
   logic [3:2][tapb_pkg::CO_W-1:0]                   x2_ff;
   logic [3:2][tapb_pkg::DIM_W-1:0]                  st2_ff;
   logic [tapb_pkg::VOL_W-1:0]                       vol2_ff;
   logic [tapb_pkg::BLK_W-1:0]                       blk2_ff;
   logic [DW-1:0]                                    data2_ff;

   // Stage 3
   tapb_pkg::ctl_type                                ctl3_ff;
   logic [tapb_pkg::T2_W-1:0]                        t2_ff;
   logic [tapb_pkg::CO_W-1:0]                        x3_ff;
   logic [tapb_pkg::DIM_W-1:0]                       st3_ff;
   logic [tapb_pkg::BOFF_W-1:0]                      boff3_ff;
   logic [DW-1:0]                                    data3_ff;

   // Stage 4
   tapb_pkg::ctl_type                                ctl4_ff;
   logic [tapb_pkg::T3_W-1:0]                        t3_ff;
   logic [tapb_pkg::BOFF_W-1:0]                      boff4_ff;
   logic [DW-1:0]                                    data4_ff;

   logic [tapb_pkg::SUM_W-1:0]                       sum;

   // Range check, scatter and stride selection
   always_comb begin
      ctl_in.valid   = in_valid;
      ctl_in.is_read = (item.action == tapb_pkg::ACT_READ);
      ctl_in.bad     = ({1'b0, item.blk} >= cfg.blocks);
      for (int k = 0; k < 4; k++) begin
         if ({1'b0, item.co[k]} >= cfg.dim[k]) begin
            ctl_in.bad = 1'b1;
         end
      end
      x_in  = '0;
      st_in = cfg.dim[3:1];
      if (item.action == tapb_pkg::ACT_READ) begin
         // later axes win a shared target
         for (int k = 0; k < 4; k++) begin
            x_in[cfg.perm[2*k +: 2]] = item.co[k];
         end
         for (int j = 1; j < 4; j++) begin
            st_in[j] = cfg.dim[cfg.perm[2*j +: 2]];
         end
      end else begin
         x_in = item.co;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff    <= x_in;
      st1_ff   <= st_in;
      vab1_ff  <= tapb_pkg::VAB_W'(cfg.dim[0]) * tapb_pkg::VAB_W'(cfg.dim[1]);
      vcd1_ff  <= tapb_pkg::VAB_W'(cfg.dim[2]) * tapb_pkg::VAB_W'(cfg.dim[3]);
      blk1_ff  <= item.blk;
      data1_ff <= {item.real_bits, item.imag_bits};

      t1_ff    <= tapb_pkg::T1_W'(st1_ff[1]) * tapb_pkg::T1_W'(x1_ff[0])
                  + tapb_pkg::T1_W'(x1_ff[1]);
      x2_ff    <= x1_ff[3:2];
      st2_ff   <= st1_ff[3:2];
      vol2_ff  <= tapb_pkg::VOL_W'(vab1_ff) * tapb_pkg::VOL_W'(vcd1_ff);
      blk2_ff  <= blk1_ff;
      data2_ff <= data1_ff;

      t2_ff    <= tapb_pkg::T2_W'(st2_ff[2]) * tapb_pkg::T2_W'(t1_ff)
                  + tapb_pkg::T2_W'(x2_ff[2]);
      x3_ff    <= x2_ff[3];
      st3_ff   <= st2_ff[3];
      boff3_ff <= tapb_pkg::BOFF_W'(blk2_ff) * tapb_pkg::BOFF_W'(vol2_ff);
      data3_ff <= data2_ff;

      t3_ff    <= tapb_pkg::T3_W'(st3_ff) * tapb_pkg::T3_W'(t2_ff)
                  + tapb_pkg::T3_W'(x3_ff);
      boff4_ff <= boff3_ff;
      data4_ff <= data3_ff;
   end

   // In-range store addresses fall below the store depth
   assign sum  = tapb_pkg::SUM_W'(boff4_ff) + tapb_pkg::SUM_W'(t3_ff);
   assign addr = ADDR_W'(sum);
   assign cmd  = ctl4_ff;
   assign data = data4_ff;

endmodule

`default_nettype wire

// ===== src/tensor_axis_permute_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------------
// request   | start / busy         | req_action, req_block_index, req_coord_a..d,
//           |                      | req_real_bits, req_imag_bits
// response  | rsp_strobe (1 cycle) | rsp_real_out, rsp_imag_out, rsp_out_of_range
// csr write | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One item is taken per cycle while busy is low. A read passes through
// four stages of small multiply-adds that form the address, then through
// the registered memory read. Stores take the same path and leave no response.
// busy is high during reset and for the cycle after it, and low otherwise.
// The response cannot be stalled; the receiver takes it in its strobe cycle.
// The element store has no clearing pass: entries hold garbage until written.

module tensor_axis_permute_buffer #(
   parameter int MAX_DIM    = 4,
   parameter int MAX_BLOCKS = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_action,
   input  wire logic [tapb_pkg::BLK_W-1:0]        req_block_index,
   input  wire logic [tapb_pkg::CO_W-1:0]         req_coord_a,
   input  wire logic [tapb_pkg::CO_W-1:0]         req_coord_b,
   input  wire logic [tapb_pkg::CO_W-1:0]         req_coord_c,
   input  wire logic [tapb_pkg::CO_W-1:0]         req_coord_d,
   input  wire logic [tapb_pkg::DATA_W-1:0]       req_real_bits,
   input  wire logic [tapb_pkg::DATA_W-1:0]       req_imag_bits,

   output logic                                   rsp_strobe,
   output logic [tapb_pkg::DATA_W-1:0]            rsp_real_out,
   output logic [tapb_pkg::DATA_W-1:0]            rsp_imag_out,
   output logic                                   rsp_out_of_range,

   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tapb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tapb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int DEPTH  = MAX_BLOCKS * MAX_DIM * MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW     = 2 * tapb_pkg::DATA_W;

   // Register fields are narrower than the size caps allow for; clip the caps
   localparam int DIM_SAT = (MAX_DIM > 7) ? 7 : MAX_DIM;
   localparam int BLK_SAT = (MAX_BLOCKS > 127) ? 127 : MAX_BLOCKS;
   localparam logic [tapb_pkg::DIM_W-1:0] DIM_CAP = tapb_pkg::DIM_W'(DIM_SAT);
   localparam logic [tapb_pkg::CNT_W-1:0] BLK_CAP = tapb_pkg::CNT_W'(BLK_SAT);

   logic [tapb_pkg::PERM_W-1:0]        perm_ff;
   logic [tapb_pkg::CNT_W-1:0]         count_ff;
   logic [3:0][tapb_pkg::DIM_W-1:0]    dim_ff;
   logic                               busy_ff;

   tapb_pkg::cfg_type                  cfg;
   tapb_pkg::item_type                 item;
   tapb_pkg::ctl_type                  cmd;
   tapb_pkg::ctl_type                  rsp_ctl_ff;
   logic                               accept;
   logic [ADDR_W-1:0]                  mem_addr;
   logic [DW-1:0]                      mem_wdata;
   logic [DW-1:0]                      mem_rdata;

   // Configuration registers, always ready: write only while idle (not enforced)
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         perm_ff   <= tapb_pkg::PERM_RESET;
         count_ff  <= tapb_pkg::COUNT_RESET;
         dim_ff[0] <= tapb_pkg::DIM_A_RESET;
         dim_ff[1] <= tapb_pkg::DIM_B_RESET;
         dim_ff[2] <= tapb_pkg::DIM_C_RESET;
         dim_ff[3] <= tapb_pkg::DIM_D_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tapb_pkg::CSR_PERM_CODE:   perm_ff   <= csr_wdata;
            tapb_pkg::CSR_BLOCK_COUNT: count_ff  <= csr_wdata[tapb_pkg::CNT_W-1:0];
            tapb_pkg::CSR_DIM_A:       dim_ff[0] <= csr_wdata[tapb_pkg::DIM_W-1:0];
            tapb_pkg::CSR_DIM_B:       dim_ff[1] <= csr_wdata[tapb_pkg::DIM_W-1:0];
            tapb_pkg::CSR_DIM_C:       dim_ff[2] <= csr_wdata[tapb_pkg::DIM_W-1:0];
            tapb_pkg::CSR_DIM_D:       dim_ff[3] <= csr_wdata[tapb_pkg::DIM_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   // Saturate sizes and count to the store's geometry
   always_comb begin
      cfg.perm   = perm_ff;
      cfg.blocks = (count_ff > BLK_CAP) ? BLK_CAP : count_ff;
      for (int k = 0; k < 4; k++) begin
         cfg.dim[k] = (dim_ff[k] > DIM_CAP) ? DIM_CAP : dim_ff[k];
      end
   end

   // Hold off items through reset and the cycle that follows
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = reset | busy_ff;
   assign accept = start & ~busy;

   always_comb begin
      item.action    = req_action;
      item.blk       = req_block_index;
      item.co[0]     = req_coord_a;
      item.co[1]     = req_coord_b;
      item.co[2]     = req_coord_c;
      item.co[3]     = req_coord_d;
      item.real_bits = req_real_bits;
      item.imag_bits = req_imag_bits;
   end

   tapb_addr #(
      .ADDR_W (ADDR_W)
   ) u_addr (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .item     (item),
      .cfg      (cfg),
      .cmd      (cmd),
      .addr     (mem_addr),
      .data     (mem_wdata)
   );

   // Out-of-range items never touch the store
   tapb_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (DW)
   ) u_mem (
      .clock    (clock),
      .en       (cmd.valid & ~cmd.bad),
      .we       (~cmd.is_read),
      .addr     (mem_addr),
      .wdata    (mem_wdata),
      .rdata_ff (mem_rdata)
   );

   // Advance control alongside the memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ctl_ff <= '0;
      end else begin
         rsp_ctl_ff <= cmd;
      end
   end

   assign rsp_strobe       = rsp_ctl_ff.valid & rsp_ctl_ff.is_read;
   assign rsp_out_of_range = rsp_ctl_ff.bad;
   assign rsp_real_out     = rsp_ctl_ff.bad ? '0 : mem_rdata[DW-1 -: tapb_pkg::DATA_W];
   assign rsp_imag_out     = rsp_ctl_ff.bad ? '0 : mem_rdata[tapb_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

// ===== src/tapb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tapb_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          req_action,
   input wire logic                          rsp_strobe,
   input wire logic [tapb_pkg::DATA_W-1:0]   rsp_real_out,
   input wire logic [tapb_pkg::DATA_W-1:0]   rsp_imag_out,
   input wire logic                          rsp_out_of_range
);

   // Every response traces back to a read taken earlier
   a_rsp_has_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && req_action == tapb_pkg::ACT_READ, 5))
      else $error("response without a matching read");

   // Every read gets a response
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == tapb_pkg::ACT_READ) |-> ##5 rsp_strobe)
      else $error("read item lost");

   // A store never produces a response
   a_store_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == tapb_pkg::ACT_STORE) |-> ##5 !rsp_strobe)
      else $error("store item produced a response");

   // Out-of-range reads return zero data
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_of_range) |-> (rsp_real_out == '0 && rsp_imag_out == '0))
      else $error("out-of-range response carries data");

   // No accept in the cycle after reset: busy must still be high there
   a_busy_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("busy low straight after reset");

endmodule

bind tensor_axis_permute_buffer tapb_checker u_tapb_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_action       (req_action),
   .rsp_strobe       (rsp_strobe),
   .rsp_real_out     (rsp_real_out),
   .rsp_imag_out     (rsp_imag_out),
   .rsp_out_of_range (rsp_out_of_range)
);

`default_nettype wire
